>>> sv/dssm_pkg.sv
// Shared types and constants for the dual stack shared memory block.
// Used by dssm_ctrl and dual_stack_shared_memory; depends on nothing.
package dssm_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_PEEK  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Stack selector values.
   localparam logic SEL_LOWER = 1'b0;
   localparam logic SEL_UPPER = 1'b1;

   // Status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam int DATA_W = 32;
   localparam int LEN_W  = 6;

   // Everything known about a result once the counters have been updated,
   // apart from the word that the memory returns in the next cycle.
   typedef struct packed {
      logic             status;
      logic             rd_ok;
      logic [LEN_W-1:0] length;
      logic             empty;
      logic             full;
   } rsp_info_type;

endpackage

>>> sv/dssm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Stand-alone; no package dependency.
module dssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next enabled read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/dssm_ctrl.sv
// Stack pointer control: both counters, memory addressing and the stage
// that waits for read data. Depends on dssm_pkg.
module dssm_ctrl #(
   parameter int CAPACITY = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic                          req_sel,
   input  logic [dssm_pkg::DATA_W-1:0]   req_value,
   input  logic                          stg_advance,
   output logic                          stg_valid,
   output dssm_pkg::rsp_info_type        stg_info,
   output logic                          mem_wr_en,
   output logic [$clog2(CAPACITY)-1:0]   mem_wr_addr,
   output logic [dssm_pkg::DATA_W-1:0]   mem_wr_data,
   output logic                          mem_rd_en,
   output logic [$clog2(CAPACITY)-1:0]   mem_rd_addr
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam logic [CNT_W:0] CAP_SUM = (CNT_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0] lower_ff, lower_in;
   logic [CNT_W-1:0] upper_ff, upper_in;
   logic             stg_valid_ff, stg_valid_in;
   dssm_pkg::rsp_info_type stg_info_ff, stg_info_in;

   logic             accept;
   logic [CNT_W:0]   sum_now, sum_next;
   logic             full_now;
   logic [CNT_W-1:0] len_now, len_next;
   logic [CNT_W+dssm_pkg::LEN_W-1:0] len_wide;
   logic             is_read;
   logic             info_status;
   logic             info_rd_ok;

   // The stage takes a new beat whenever it is empty or being drained,
   // and never while reset is high.
   assign req_ready = !reset && (!stg_valid_ff || stg_advance);
   assign accept    = req_valid && req_ready;

   assign sum_now  = {1'b0, lower_ff} + {1'b0, upper_ff};
   assign full_now = sum_now >= CAP_SUM;
   assign len_now  = (req_sel == dssm_pkg::SEL_LOWER) ? lower_ff : upper_ff;
   assign is_read  = (req_op == dssm_pkg::OP_POP) || (req_op == dssm_pkg::OP_PEEK);

   // Counter update and memory access for the accepted operation.
   always_comb begin
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_addr = ADDR_W'(lower_ff);
      mem_rd_addr = ADDR_W'(lower_ff - CNT_W'(1));
      info_status = dssm_pkg::STATUS_OK;
      info_rd_ok  = 1'b0;
      if (req_sel == dssm_pkg::SEL_UPPER) begin
         mem_wr_addr = ADDR_W'(CAP_CNT - upper_ff - CNT_W'(1));
         mem_rd_addr = ADDR_W'(CAP_CNT - upper_ff);
      end
      case (req_op)
         dssm_pkg::OP_PUSH: begin
            if (full_now) begin
               info_status = dssm_pkg::STATUS_ERR;
            end else begin
               mem_wr_en = accept;
               if (req_sel == dssm_pkg::SEL_LOWER) begin
                  lower_in = lower_ff + CNT_W'(1);
               end else begin
                  upper_in = upper_ff + CNT_W'(1);
               end
            end
         end
         dssm_pkg::OP_POP, dssm_pkg::OP_PEEK: begin
            if (len_now == '0) begin
               info_status = dssm_pkg::STATUS_ERR;
            end else begin
               mem_rd_en  = accept;
               info_rd_ok = 1'b1;
               if (req_op == dssm_pkg::OP_POP) begin
                  if (req_sel == dssm_pkg::SEL_LOWER) begin
                     lower_in = lower_ff - CNT_W'(1);
                  end else begin
                     upper_in = upper_ff - CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            if (req_sel == dssm_pkg::SEL_LOWER) begin
               lower_in = '0;
            end else begin
               upper_in = '0;
            end
         end
      endcase
   end

   assign mem_wr_data = req_value;

   // Flags seen after the operation.
   assign sum_next = {1'b0, lower_in} + {1'b0, upper_in};
   assign len_next = (req_sel == dssm_pkg::SEL_LOWER) ? lower_in : upper_in;
   assign len_wide = {{dssm_pkg::LEN_W{1'b0}}, len_next};
   assign stg_info_in = {info_status, info_rd_ok, len_wide[dssm_pkg::LEN_W-1:0],
                         len_next == '0, sum_next >= CAP_SUM};

   assign stg_valid_in = accept || (stg_valid_ff && !stg_advance);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff     <= '0;
         upper_ff     <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         if (accept) begin
            lower_ff <= lower_in;
            upper_ff <= upper_in;
         end
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_info_ff <= stg_info_in;
      end
   end

   assign stg_valid = stg_valid_ff;
   assign stg_info  = stg_info_ff;

   // The two stacks never overlap.
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      sum_now <= CAP_SUM)
      else $error("stacks overlap");

   // A successful push grows the stacks by exactly one entry.
   a_push_grows : assert property (@(posedge clock) disable iff (reset)
      accept && (req_op == dssm_pkg::OP_PUSH) && !full_now
      |=> sum_now == $past(sum_now) + (CNT_W + 1)'(1))
      else $error("push did not grow the stacks by one");

   // A failed pop or peek leaves both counters as they were.
   a_err_keeps : assert property (@(posedge clock) disable iff (reset)
      accept && is_read && (len_now == '0)
      |=> $stable(lower_ff) && $stable(upper_ff))
      else $error("failed read changed a counter");

   // A read is only issued for an entry below a stack's count.
   a_read_valid : assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> len_now != '0)
      else $error("read issued on an empty stack");

endmodule

>>> sv/dual_stack_shared_memory.sv
// Top level of the two-stacks-in-one-memory block: word RAM, pointer
// control and result register. Depends on dssm_pkg, dssm_ram, dssm_ctrl.
//
//   channel  direction  tdata fields (low bit up)                        tuser
//   req      in         push_value[31:0]                                 operation, stack_select
//   rsp      out        read_value, stack_length, selected_empty, full   status
//
// One operation is accepted per cycle while results are being taken; a
// result goes from its request beat via the registered RAM read and the
// waiting stage to the result register. Reset clears both stack counts
// and holds off requests; the word memory is not cleared. A stalled result
// holds the result register and the waiting stage, and requests stop once
// both are full.
module dual_stack_shared_memory #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // push_value[31:0]
   input  logic [2:0]  req_tuser,   // operation[1:0], stack_select[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value[31:0], stack_length[37:32],
                                    // selected_empty[38], memory_full[39]
   output logic [0:0]  rsp_tuser    // status[0]
);

   localparam int ADDR_W = $clog2(CAPACITY);

   logic                          mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]             mem_wr_addr, mem_rd_addr;
   logic [dssm_pkg::DATA_W-1:0]   mem_wr_data, mem_rd_data;
   logic                          stg_valid, stg_advance;
   dssm_pkg::rsp_info_type        stg_info;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [39:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_status_ff;
   logic [dssm_pkg::DATA_W-1:0]   read_value;

   dssm_ram #(
      .WIDTH (dssm_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   dssm_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser[1:0]),
      .req_sel     (req_tuser[2]),
      .req_value   (req_tdata),
      .stg_advance (stg_advance),
      .stg_valid   (stg_valid),
      .stg_info    (stg_info),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr)
   );

   // The waiting stage moves into the result register when that is free.
   assign stg_advance  = stg_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = stg_advance || (rsp_valid_ff && !rsp_tready);

   // Read data counts only for a successful pop or peek.
   assign read_value  = stg_info.rd_ok ? mem_rd_data : '0;
   assign rsp_data_in = {stg_info.full, stg_info.empty, stg_info.length, read_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (stg_advance) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= stg_info.status;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_status_ff;

   // An error result never carries read data.
   a_err_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == dssm_pkg::STATUS_ERR) |-> rsp_tdata[31:0] == '0)
      else $error("error result carries data");

   // An empty stack reports a zero length.
   a_empty_len : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38] && (CAPACITY < 64) |-> rsp_tdata[37:32] == '0)
      else $error("empty flag disagrees with length");

   // A result beat that is not taken stays offered and unchanged.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

endmodule
